// File: rtl/core/mrrc_pkg.sv
`default_nettype none
package mrrc_pkg;

    // One received word on the input channel.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_word;

    // One frame result on the output channel.
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] payload;
        logic [6:0]  frame_bytes;
    } t_out_word;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd1;
    localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame overhead: address, function code, byte count, two CRC bytes.
    localparam logic [6:0] FRAME_OVERHEAD = 7'd5;
    // Offset of the first data byte within the frame.
    localparam logic [6:0] DATA_OFFSET    = 7'd3;
    localparam logic [6:0] COUNT_MAX      = 7'd127;

    localparam logic [3:0] PAYLOAD_LEN_RESET = 4'd2;
    localparam logic       REG_PAYLOAD_LEN   = 1'b0;

endpackage
`default_nettype wire

// File: rtl/core/mrrc_crc8.sv
`default_nettype none
// Byte-wide CRC-16/Modbus update, unrolled over the eight bit steps.
module mrrc_crc8 (
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_crc
);

    always_comb begin
        logic [15:0] v_acc;
        v_acc = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (v_acc[0]) begin
                v_acc = (v_acc >> 1) ^ mrrc_pkg::CRC_POLY;
            end else begin
                v_acc = v_acc >> 1;
            end
        end
        o_crc = v_acc;
    end

endmodule
`default_nettype wire

// File: rtl/core/mrrc_frame.sv
`default_nettype none
// Frame state and per-word evaluation. Consumes the registered input word
// when i_go is high and produces a result when that word ends the frame.
module mrrc_frame #(
    parameter int MAX_PAYLOAD_BYTES = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_go,
    input  wire mrrc_pkg::t_in_word  i_word,
    input  wire logic [3:0]          i_payload_len,
    output logic                     o_res_valid,
    output mrrc_pkg::t_out_word      o_res
);

    localparam int SHIFT_W = 8 * MAX_PAYLOAD_BYTES;

    logic [15:0]        r_crc_acc,       n_crc_acc;
    logic [6:0]         r_byte_count,    n_byte_count;
    logic [7:0]         r_recent_byte,   n_recent_byte;
    logic [7:0]         r_older_byte,    n_older_byte;
    logic [SHIFT_W-1:0] r_payload_shift, n_payload_shift;

    logic [15:0]        crc_step;
    logic [15:0]        crc_now;
    logic [6:0]         keep;
    logic [6:0]         count_now;
    logic [SHIFT_W-1:0] shift_now;
    logic [15:0]        crc_got;

    mrrc_crc8 u_crc8 (
        .i_crc  (r_crc_acc),
        .i_byte (r_older_byte),
        .o_crc  (crc_step)
    );

    always_comb begin
        keep = (i_payload_len > 4'(MAX_PAYLOAD_BYTES)) ? 7'(MAX_PAYLOAD_BYTES)
                                                       : {3'b000, i_payload_len};
        // The newest two bytes are held back so the trailing CRC never enters.
        crc_now   = (r_byte_count >= 7'd2) ? crc_step : r_crc_acc;
        shift_now = r_payload_shift;
        if ((r_byte_count >= mrrc_pkg::DATA_OFFSET) &&
            (r_byte_count < (mrrc_pkg::DATA_OFFSET + keep))) begin
            shift_now = SHIFT_W'({r_payload_shift, i_word.rx_byte});
        end
        count_now = (r_byte_count < mrrc_pkg::COUNT_MAX) ? (r_byte_count + 7'd1)
                                                         : r_byte_count;
        crc_got   = {i_word.rx_byte, r_recent_byte};

        o_res_valid       = i_go && i_word.frame_end;
        o_res.payload     = 64'(shift_now);
        o_res.frame_bytes = count_now;
        if (count_now != (mrrc_pkg::FRAME_OVERHEAD + {3'b000, i_payload_len})) begin
            o_res.status = mrrc_pkg::STATUS_BAD_LEN;
        end else if (crc_now != crc_got) begin
            o_res.status = mrrc_pkg::STATUS_BAD_CRC;
        end else begin
            o_res.status = mrrc_pkg::STATUS_OK;
        end

        n_crc_acc       = r_crc_acc;
        n_byte_count    = r_byte_count;
        n_recent_byte   = r_recent_byte;
        n_older_byte    = r_older_byte;
        n_payload_shift = r_payload_shift;
        if (i_go) begin
            if (i_word.frame_end) begin
                n_crc_acc       = mrrc_pkg::CRC_INIT;
                n_byte_count    = '0;
                n_recent_byte   = '0;
                n_older_byte    = '0;
                n_payload_shift = '0;
            end else begin
                n_crc_acc       = crc_now;
                n_byte_count    = count_now;
                n_recent_byte   = i_word.rx_byte;
                n_older_byte    = r_recent_byte;
                n_payload_shift = shift_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_acc       <= mrrc_pkg::CRC_INIT;
            r_byte_count    <= '0;
            r_recent_byte   <= '0;
            r_older_byte    <= '0;
            r_payload_shift <= '0;
        end else begin
            r_crc_acc       <= n_crc_acc;
            r_byte_count    <= n_byte_count;
            r_recent_byte   <= n_recent_byte;
            r_older_byte    <= n_older_byte;
            r_payload_shift <= n_payload_shift;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/modbus_rtu_response_checker_top.sv
`default_nettype none
// Modbus RTU read-response checker. Frame bytes arrive one word per cycle
// on the input channel, with frame_end set on the last byte. The block runs
// CRC-16/Modbus over all bytes but the final two, compares it with the
// trailing little-endian CRC, checks that the frame holds exactly five plus
// payload_len bytes, and collects the data bytes from offset 3 as a
// big-endian value. On the last byte one result word carries the status
// (0 ok, 1 wrong length, 2 CRC mismatch; a wrong length wins), the payload
// and the saturating byte count, and the block is ready for the next frame.
// Throughput is one byte per cycle unless a last byte waits: an input
// register feeds a single pass of logic built around a byte-wide unrolled
// CRC update, which writes the frame state and the output register.
// A last byte passes both registers. Bytes that do not end a frame are
// taken even while a result word waits downstream; only a last byte waits
// for the output register to drain. payload_len sits at byte address 0 of
// the APB-style port and must only be written while no frame is in flight.
module modbus_rtu_response_checker_top #(
    parameter int MAX_PAYLOAD_BYTES = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input channel.
    input  wire logic                i_in_valid,
    input  wire mrrc_pkg::t_in_word  i_in_data,
    output logic                     o_in_stall,
    // Output channel.
    output logic                     o_out_valid,
    output mrrc_pkg::t_out_word      o_out_data,
    input  wire logic                i_out_stall,
    // Configuration port.
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [3:0]          r_payload_len;
    logic                r_in_valid;
    mrrc_pkg::t_in_word  r_in_word;
    logic                r_out_valid, n_out_valid;
    mrrc_pkg::t_out_word r_out_word;

    logic                out_blocked;
    logic                stage_go;
    logic                in_take;
    logic                res_valid;
    mrrc_pkg::t_out_word res_word;
    logic                cfg_write;

    // The configuration register. Only register index 0 exists; any write
    // whose word address decodes elsewhere is ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == mrrc_pkg::REG_PAYLOAD_LEN) ? {28'd0, r_payload_len}
                                                               : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_len <= mrrc_pkg::PAYLOAD_LEN_RESET;
        end else begin
            if (cfg_write && (paddr[2] == mrrc_pkg::REG_PAYLOAD_LEN)) begin
                r_payload_len <= pwdata[3:0];
            end
        end
    end

    // The output register is blocked when it holds a word the consumer
    // refuses this cycle. A word that ends a frame then waits in the input
    // register; any other word moves on since it produces no result.
    assign out_blocked = r_out_valid && i_out_stall;
    assign stage_go    = r_in_valid && !(r_in_word.frame_end && out_blocked);
    assign o_in_stall  = r_in_valid && !stage_go;
    assign in_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (stage_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_data;
        end
    end

    mrrc_frame #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (stage_go),
        .i_word        (r_in_word),
        .i_payload_len (r_payload_len),
        .o_res_valid   (res_valid),
        .o_res         (res_word)
    );

    // A new result only arrives when the output register is free or being
    // emptied in this same cycle.
    always_comb begin
        if (res_valid) begin
            n_out_valid = 1'b1;
        end else if (out_blocked) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

endmodule
`default_nettype wire

// File: rtl/core/mrrc_checker.sv
`default_nettype none
// Port-level checks for the response checker.
module mrrc_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire mrrc_pkg::t_in_word  i_in_data,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire mrrc_pkg::t_out_word o_out_data,
    input wire logic                i_out_stall
);

    // A refused result word must stay and hold its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // Status never takes the unused code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == mrrc_pkg::STATUS_OK ||
                         o_out_data.status == mrrc_pkg::STATUS_BAD_LEN ||
                         o_out_data.status == mrrc_pkg::STATUS_BAD_CRC))
        else $error("illegal status code");

    // A frame judged good has at least the fixed overhead bytes.
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == mrrc_pkg::STATUS_OK) |->
            (o_out_data.frame_bytes >= mrrc_pkg::FRAME_OVERHEAD))
        else $error("ok status on a too short frame");

    // A new result word needs a last byte accepted through the input register.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && !o_in_stall && i_in_data.frame_end, 2))
        else $error("result word without a frame end");

endmodule

bind modbus_rtu_response_checker_top mrrc_checker u_mrrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
`default_nettype wire

// File: tb/modbus_rtu_response_checker_top_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the Modbus RTU read-response checker. Frames are
// fed one word per handshake, and a cycle-free software copy of the checker
// predicts the result word for every frame end. The receiving process checks
// each result against the oldest prediction, field by field.
module modbus_rtu_response_checker_top_tb;

    localparam int CLK_HALF_NS       = 4;
    localparam int RESET_CYCLES      = 8;
    localparam int MAX_PAYLOAD_BYTES = 8;
    // A last byte passes the input and output registers before its result
    // word; this margin covers anything still moving through the block.
    localparam int SETTLE_CYCLES     = 6;
    // Long receiver hold-off used to fill the block up.
    localparam int HOLD_CYCLES       = 300;
    // Longest quiet stretch that a correct run can show is the hold-off
    // above; the watchdog allows several times that.
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int WORDS_PER_PHASE   = 150;
    localparam int PRESSURE_FRAMES   = 30;
    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    mrrc_pkg::t_in_word  i_in_data = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    mrrc_pkg::t_out_word o_out_data;
    logic                i_out_stall = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    modbus_rtu_response_checker_top #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // Predicted frame state. It mirrors what the checker holds between
    // bytes: the running CRC, the byte count, the two-byte delay line that
    // keeps the trailing CRC pair out of the sum, and the collected payload.
    logic [15:0] frame_crc = mrrc_pkg::CRC_INIT;
    logic [6:0]  frame_count = '0;
    logic [7:0]  held_recent = '0;
    logic [7:0]  held_older = '0;
    logic [63:0] frame_payload = '0;
    logic [3:0]  cfg_payload_len = mrrc_pkg::PAYLOAD_LEN_RESET;

    // Result words predicted but not yet seen at the output, oldest first.
    mrrc_pkg::t_out_word pending_results[$];
    // Frame under construction for the sender.
    logic [7:0]  tx_frame[$];

    int mismatch_count = 0;
    int words_sent = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    logic pressure_on = 1'b0;
    int hold_count = 0;
    int quiet_cycles = 0;

    // One byte of the reflected CRC-16 with polynomial 0xA001.
    function automatic logic [15:0] crc16_modbus_step(input logic [15:0] acc,
                                                      input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ mrrc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Advances the predicted frame state by one accepted byte. On the last
    // byte of a frame it queues the result word and clears the frame.
    task automatic predict_frame_byte(input logic [7:0] b, input logic is_end);
        logic [6:0]  pos;
        logic [6:0]  keep;
        logic [15:0] trailer;
        mrrc_pkg::t_out_word res;
        pos  = frame_count;
        keep = (cfg_payload_len > MAX_PAYLOAD_BYTES) ? 7'(MAX_PAYLOAD_BYTES)
                                                     : 7'(cfg_payload_len);
        if (frame_count >= 2) frame_crc = crc16_modbus_step(frame_crc, held_older);
        if (pos >= mrrc_pkg::DATA_OFFSET && pos < mrrc_pkg::DATA_OFFSET + keep) begin
            frame_payload = {frame_payload[55:0], b};
        end
        // The trailer pair is little-endian: the newest byte is the high half.
        trailer     = {b, held_recent};
        held_older  = held_recent;
        held_recent = b;
        if (frame_count != mrrc_pkg::COUNT_MAX) frame_count = frame_count + 7'd1;
        if (is_end) begin
            // A wrong length takes priority over a CRC mismatch.
            if (frame_count != mrrc_pkg::FRAME_OVERHEAD + 7'(cfg_payload_len)) begin
                res.status = mrrc_pkg::STATUS_BAD_LEN;
            end else if (frame_crc != trailer) begin
                res.status = mrrc_pkg::STATUS_BAD_CRC;
            end else begin
                res.status = mrrc_pkg::STATUS_OK;
            end
            res.payload     = frame_payload;
            res.frame_bytes = frame_count;
            pending_results.push_back(res);
            frame_crc     = mrrc_pkg::CRC_INIT;
            frame_count   = '0;
            held_recent   = '0;
            held_older    = '0;
            frame_payload = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatch_count++;
    endtask

    // Offers one word and waits for it to be taken. Valid is left high so a
    // following word goes out back to back; callers that pause lower it.
    task automatic send_word(input logic [7:0] b, input logic is_end);
        mrrc_pkg::t_in_word w;
        w.rx_byte   = b;
        w.frame_end = is_end;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        predict_frame_byte(b, is_end);
    endtask

    task automatic send_frame();
        foreach (tx_frame[i]) send_word(tx_frame[i], i == tx_frame.size() - 1);
    endtask

    task automatic append_crc();
        logic [15:0] c;
        c = mrrc_pkg::CRC_INIT;
        foreach (tx_frame[i]) c = crc16_modbus_step(c, tx_frame[i]);
        tx_frame.push_back(c[7:0]);
        tx_frame.push_back(c[15:8]);
    endtask

    // A read response with n data bytes and a correct CRC.
    task automatic build_response(input int n);
        tx_frame.delete();
        tx_frame.push_back(8'($urandom_range(1, 247)));
        tx_frame.push_back(FUNC_READ_HOLDING);
        tx_frame.push_back(8'(n));
        repeat (n) tx_frame.push_back(8'($urandom));
        append_crc();
    endtask

    // Most frames are well formed so that the payload path and the CRC match
    // are exercised; the rest carry a broken CRC, a wrong length or noise.
    task automatic send_random_frame();
        int pick;
        int n;
        int idx;
        pick = $urandom_range(99);
        if (pick < 70) begin
            build_response(int'(cfg_payload_len));
        end else if (pick < 80) begin
            build_response(int'(cfg_payload_len));
            idx = tx_frame.size() - 1 - $urandom_range(1);
            tx_frame[idx] = tx_frame[idx] ^ (8'h01 << $urandom_range(7));
        end else if (pick < 90) begin
            n = $urandom_range(0, 10);
            if (n == cfg_payload_len) n = n + 1;
            build_response(n);
        end else begin
            tx_frame.delete();
            n = $urandom_range(1, 8);
            repeat (n) tx_frame.push_back(8'($urandom));
        end
        send_frame();
    endtask

    // Stops offering words and waits until every predicted result is back
    // and the pipeline has had time to empty.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes only happen with no frame in flight.
    task automatic set_payload_len(input logic [3:0] len);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {mrrc_pkg::REG_PAYLOAD_LEN, 2'b00};
        pwdata  <= {28'd0, len};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_payload_len = len;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1: begin
                sender_idle_pct = 55;
                receiver_stall_pct <= 0;
            end
            2: begin
                sender_idle_pct = 0;
                receiver_stall_pct <= 55;
            end
            3: begin
                sender_idle_pct = 11;
                receiver_stall_pct <= 11;
            end
            default: begin
                sender_idle_pct = 0;
                receiver_stall_pct <= 0;
            end
        endcase
    endtask

    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Hand-built frames at the reset payload length of two, then one at
    // length zero: a clean frame, one-byte and two-byte frames where the
    // trailer comes from the cleared delay line, a broken CRC, and a frame
    // where both checks fail so the length error must win.
    task automatic test_directed();
        set_idling(0);
        tx_frame = '{8'h01, FUNC_READ_HOLDING, 8'h04, 8'hFF, 8'h00};
        append_crc();
        send_frame();
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        tx_frame = '{8'hF7, FUNC_READ_HOLDING, 8'h04, 8'h00, 8'hFF};
        append_crc();
        tx_frame[5] = tx_frame[5] ^ 8'h80;
        send_frame();
        tx_frame = '{8'hFF, 8'h00, 8'hFF, 8'h00};
        send_frame();
        set_payload_len(4'd0);
        tx_frame = '{8'h01, FUNC_READ_HOLDING, 8'h00};
        append_crc();
        send_frame();
    endtask

    // Random frames under a range of payload lengths, including zero and
    // lengths beyond what the payload register can hold, while the idling
    // pattern of both sides changes from phase to phase.
    task automatic test_random_phases();
        logic [3:0] lens[8];
        int stop_at;
        lens = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd2};
        for (int p = 0; p < 8; p++) begin
            set_payload_len(lens[p]);
            set_idling(p % 4);
            stop_at = words_sent + WORDS_PER_PHASE;
            while (words_sent < stop_at) send_random_frame();
        end
    endtask

    // The receiver holds off for a long stretch while short frames keep
    // coming, so result words back up and the last byte of a frame has to
    // wait at the input.
    task automatic test_backpressure();
        wait_drained();
        set_idling(0);
        pressure_on <= 1'b1;
        for (int f = 0; f < PRESSURE_FRAMES; f++) begin
            if (f % 2 == 0) begin
                send_word(8'($urandom), 1'b1);
            end else begin
                build_response(int'(cfg_payload_len));
                send_frame();
            end
        end
        pressure_on <= 1'b0;
    endtask

    // A frame longer than the byte counter can hold: the count saturates.
    task automatic test_long_frame();
        int n;
        wait_drained();
        set_idling(3);
        n = $urandom_range(128, 140);
        tx_frame.delete();
        repeat (n) tx_frame.push_back(8'($urandom));
        send_frame();
    endtask

    initial begin
        apply_reset();
        test_directed();
        test_random_phases();
        test_backpressure();
        test_long_frame();
        wait_drained();
        if (mismatch_count == 0) begin
            $display("modbus_rtu_response_checker_top_tb OK");
        end else begin
            $display("modbus_rtu_response_checker_top_tb NOT OK");
        end
        $finish;
    end

    // Output side. Values read right after the edge are the ones the block
    // saw at that edge, since all updates land later in the time step.
    always @(posedge i_clk) begin
        mrrc_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with none expected",
                                64'(o_out_data.payload), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    report_mismatch("status", 64'(o_out_data.status), 64'(want.status));
                end
                if (o_out_data.payload !== want.payload) begin
                    report_mismatch("payload", o_out_data.payload, want.payload);
                end
                if (o_out_data.frame_bytes !== want.frame_bytes) begin
                    report_mismatch("frame_bytes", 64'(o_out_data.frame_bytes),
                                    64'(want.frame_bytes));
                end
            end
        end
        // During a pressure stretch the hold-off is counted here; otherwise
        // the stall follows the current random rate.
        if (pressure_on && hold_count < HOLD_CYCLES) begin
            i_out_stall <= 1'b1;
            hold_count  <= hold_count + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
            if (!pressure_on) hold_count <= 0;
        end
    end

    // Ends the run if neither channel moves a word for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("modbus_rtu_response_checker_top_tb NOT OK");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/core/mrrc_pkg.sv
rtl/core/mrrc_crc8.sv
rtl/core/mrrc_frame.sv
rtl/core/modbus_rtu_response_checker_top.sv
rtl/core/mrrc_checker.sv
tb/modbus_rtu_response_checker_top_tb.sv
